// ----- design/contiguous_fit_allocator_unit_defines.svh -----
// assertion macros used by the checker file of the allocator
`ifndef CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- design/cfa_pkg.sv -----
// package of the contiguous fit allocator: defaults, codes and state type
package cfa_pkg;

  localparam int CELLS_DEF   = 1024;
  localparam int ID_BITS_DEF = 16;

  // fixed port widths
  localparam int ID_W    = 16;
  localparam int LEN_W   = 11;
  localparam int START_W = 10;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register map, word index taken from paddr[2]
  localparam logic [0:0] REG_FIT_POLICY = 1'b0;

  // placement rules
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_WIPE,
    ST_DONE
  } state_e;

endpackage

// ----- design/contiguous_fit_allocator_unit.sv -----
// contiguous fit allocator: owner map in a memory, scanned by one sequencer
// throughput: one request at a time, the next can be taken in the cycle the result shows;
// the scan, run write and clear sweep each go through the owner map one cell per cycle
// reset: a clearing pass writes every cell free, input stalled meanwhile;
// fit_policy resets to worst fit, configuration writes are taken during the pass
module contiguous_fit_allocator_unit #(
  parameter int CELLS   = cfa_pkg::CELLS_DEF,
  parameter int ID_BITS = cfa_pkg::ID_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [cfa_pkg::ID_W-1:0]   owner_id_i,
  input  logic [cfa_pkg::LEN_W-1:0]  run_length_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       success_o,
  output logic [cfa_pkg::START_W-1:0] start_cell_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfa_pkg::APB_AW-1:0] paddr,
  input  logic [cfa_pkg::APB_DW-1:0] pwdata,
  output logic [cfa_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int AW   = $clog2(CELLS);
  localparam int LW   = $clog2(CELLS + 1);
  localparam int CMPW = (LW > cfa_pkg::LEN_W) ? LW : cfa_pkg::LEN_W;

  cfa_pkg::state_e state_q, state_d;

  logic [1:0]         fit_policy_q;
  logic [LW-1:0]      cnt_q, cnt_d;
  logic               iss_done_q, iss_done_d;
  logic               p_vld_q, p_vld_d;
  logic               p_term_q, p_term_d;
  logic [AW-1:0]      p_idx_q, p_idx_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [LW-1:0]      need_q, need_d;
  logic [AW-1:0]      run_start_q, run_start_d;
  logic [LW-1:0]      run_len_q, run_len_d;
  logic [AW-1:0]      best_start_q, best_start_d;
  logic [LW-1:0]      best_len_q, best_len_d;
  logic               found_q, found_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [LW-1:0]      rem_q, rem_d;
  logic               res_ok_q, res_ok_d;
  logic [cfa_pkg::START_W-1:0] res_start_q, res_start_d;
  logic               out_valid_q, out_valid_d;
  logic               out_success_q, out_success_d;
  logic [cfa_pkg::START_W-1:0] out_start_q, out_start_d;

  logic [ID_BITS-1:0] cell_mem [CELLS];
  logic [ID_BITS-1:0] mem_rdata_q;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;

  logic               in_xfer, out_free, cfg_wr;
  logic [ID_BITS-1:0] in_id;
  logic               req_bad;
  logic               cell_free, fits, better, last_issue;

  assign in_xfer  = in_valid_i && (state_q == cfa_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_id    = ID_BITS'(owner_id_i);
  assign req_bad  = (in_id == '0) ||
                    ((operation_i == cfa_pkg::OP_ALLOC) &&
                     ((run_length_i == '0) ||
                      (CMPW'(run_length_i) > CMPW'(CELLS))));

  assign last_issue = (cnt_q == LW'(CELLS));
  assign cell_free  = !p_term_q && (mem_rdata_q == '0);
  assign fits       = run_len_q >= need_q;

  // policy compare of the closed run against the best one so far
  always_comb begin
    case (fit_policy_q)
      cfa_pkg::POL_BEST:  better = !found_q || (run_len_q < best_len_q);
      cfa_pkg::POL_WORST: better = !found_q || (run_len_q > best_len_q);
      default:            better = !found_q;
    endcase
  end

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == cfa_pkg::REG_FIT_POLICY) begin
      prdata = cfa_pkg::APB_DW'(fit_policy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= cfa_pkg::POL_WORST;
    end else if (cfg_wr && (paddr[2] == cfa_pkg::REG_FIT_POLICY)) begin
      fit_policy_q <= pwdata[1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfa_pkg::ST_INIT: begin
        if (cnt_q == LW'(CELLS - 1)) state_d = cfa_pkg::ST_IDLE;
      end
      cfa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (req_bad) state_d = cfa_pkg::ST_DONE;
          else if (operation_i == cfa_pkg::OP_CLEAR) state_d = cfa_pkg::ST_WIPE;
          else state_d = cfa_pkg::ST_SCAN;
        end
      end
      cfa_pkg::ST_SCAN: begin
        if (p_vld_q && p_term_q) state_d = cfa_pkg::ST_PLACE;
      end
      cfa_pkg::ST_PLACE: begin
        if (!found_q || (rem_q == LW'(1))) state_d = cfa_pkg::ST_DONE;
      end
      cfa_pkg::ST_WIPE: begin
        if (p_vld_q && p_term_q) state_d = cfa_pkg::ST_DONE;
      end
      cfa_pkg::ST_DONE: begin
        if (out_free) state_d = cfa_pkg::ST_IDLE;
      end
      default: state_d = cfa_pkg::ST_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d         = cnt_q;
    iss_done_d    = iss_done_q;
    p_vld_d       = 1'b0;
    p_term_d      = p_term_q;
    p_idx_d       = p_idx_q;
    id_d          = id_q;
    need_d        = need_q;
    run_start_d   = run_start_q;
    run_len_d     = run_len_q;
    best_start_d  = best_start_q;
    best_len_d    = best_len_q;
    found_d       = found_q;
    ptr_d         = ptr_q;
    rem_d         = rem_q;
    res_ok_d      = res_ok_q;
    res_start_d   = res_start_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_success_d = out_success_q;
    out_start_d   = out_start_q;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = cnt_q[AW-1:0];
    mem_waddr     = cnt_q[AW-1:0];

    // read issue shared by the scan and the clear sweep
    if (((state_q == cfa_pkg::ST_SCAN) || (state_q == cfa_pkg::ST_WIPE)) && !iss_done_q) begin
      p_vld_d  = 1'b1;
      p_term_d = last_issue;
      p_idx_d  = cnt_q[AW-1:0];
      mem_re   = !last_issue;
      cnt_d    = cnt_q + LW'(1);
      if (last_issue) iss_done_d = 1'b1;
    end

    unique case (state_q)
      cfa_pkg::ST_INIT: begin
        mem_we = 1'b1;
        cnt_d  = (cnt_q == LW'(CELLS - 1)) ? '0 : cnt_q + LW'(1);
      end
      cfa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          id_d        = in_id;
          need_d      = LW'(run_length_i);
          cnt_d       = '0;
          iss_done_d  = 1'b0;
          run_len_d   = '0;
          best_len_d  = '0;
          found_d     = 1'b0;
          res_ok_d    = 1'b0;
          res_start_d = '0;
        end
      end
      cfa_pkg::ST_SCAN: begin
        if (p_vld_q) begin
          if (cell_free) begin
            if (run_len_q == '0) run_start_d = p_idx_q;
            run_len_d = run_len_q + LW'(1);
          end else begin
            if (fits && better) begin
              best_start_d = run_start_q;
              best_len_d   = run_len_q;
              found_d      = 1'b1;
            end
            run_len_d = '0;
          end
          if (p_term_q) begin
            ptr_d = (fits && better) ? run_start_q : best_start_q;
            rem_d = need_q;
          end
        end
      end
      cfa_pkg::ST_PLACE: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q;
          ptr_d     = ptr_q + AW'(1);
          rem_d     = rem_q - LW'(1);
          if (rem_q == LW'(1)) begin
            res_ok_d    = 1'b1;
            res_start_d = cfa_pkg::START_W'(best_start_q);
          end
        end
      end
      cfa_pkg::ST_WIPE: begin
        if (p_vld_q && !p_term_q && (mem_rdata_q == id_q)) begin
          mem_we    = 1'b1;
          mem_waddr = p_idx_q;
        end
        if (p_vld_q && p_term_q) res_ok_d = 1'b1;
      end
      cfa_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_success_d = res_ok_q;
          out_start_d   = res_start_q;
        end
      end
      default: begin
      end
    endcase
  end

  // owner map, written with the run owner or with free
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= (state_q == cfa_pkg::ST_PLACE) ? id_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= cell_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfa_pkg::ST_INIT;
      cnt_q       <= '0;
      iss_done_q  <= 1'b0;
      p_vld_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_done_q  <= iss_done_d;
      p_vld_q     <= p_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_term_q      <= p_term_d;
    p_idx_q       <= p_idx_d;
    id_q          <= id_d;
    need_q        <= need_d;
    run_start_q   <= run_start_d;
    run_len_q     <= run_len_d;
    best_start_q  <= best_start_d;
    best_len_q    <= best_len_d;
    ptr_q         <= ptr_d;
    rem_q         <= rem_d;
    res_ok_q      <= res_ok_d;
    res_start_q   <= res_start_d;
    out_success_q <= out_success_d;
    out_start_q   <= out_start_d;
  end

  assign in_stall_o   = (state_q != cfa_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign success_o    = out_success_q;
  assign start_cell_o = out_start_q;

endmodule

// ----- design/cfa_checker.sv -----
// port-level checks of the contiguous fit allocator, bound to its top level
`include "contiguous_fit_allocator_unit_defines.svh"

module cfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        operation_i,
  input logic [cfa_pkg::ID_W-1:0]    owner_id_i,
  input logic [cfa_pkg::LEN_W-1:0]   run_length_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        success_o,
  input logic [cfa_pkg::START_W-1:0] start_cell_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [cfa_pkg::APB_AW-1:0]  paddr,
  input logic [cfa_pkg::APB_DW-1:0]  pwdata,
  input logic [cfa_pkg::APB_DW-1:0]  prdata,
  input logic                        pready
);

  // a stalled result transfer keeps its payload
  `CFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(success_o) && $stable(start_cell_o))

  // failed requests report cell zero
  `CFA_ASSERT_NOW(a_fail_start_zero, clk_i, rst_ni, out_valid_o && !success_o,
                  start_cell_o == '0)

  // one request at a time: busy right after taking one
  `CFA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
                   in_stall_o)

endmodule

bind contiguous_fit_allocator_unit cfa_checker u_cfa_checker (.*);
